// ===== rtl/max_interval_overlap_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef MAX_INTERVAL_OVERLAP_CORE_ASSERT_SVH
`define MAX_INTERVAL_OVERLAP_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MIO_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MIO_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define MIO_ASSERT_RST(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/mio_pkg.sv =====
// Package: shared types and constants of the interval overlap core.
`timescale 1ns / 1ps
package mio_pkg;
   localparam int MAX_INTERVALS_DEF = 1024;
   localparam int TIME_BITS_DEF     = 32;
   localparam int FIELD_W           = 32;
   localparam int ROOMS_W           = 11;

   typedef struct packed {
      logic clear;
      logic enable;
   } cover_ctl_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_FETCH  = 6'b000010,
      ST_LATCH  = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_DRAIN  = 6'b010000,
      ST_UPDATE = 6'b100000
   } state_type;
endpackage

// ===== rtl/mio_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module mio_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
endmodule

// ===== rtl/mio_cover_unit.sv =====
// Shared compare unit: counts stored intervals that cover a reference instant.
`timescale 1ns / 1ps
module mio_cover_unit #(
   parameter int TW = 32,
   parameter int CW = 11
) (
   input  logic                  clock,
   input  mio_pkg::cover_ctl_type ctl,
   input  logic [TW-1:0]         ref_start,
   input  logic [TW-1:0]         cand_start,
   input  logic [TW-1:0]         cand_end,
   output logic [CW-1:0]         count_ff
);
   logic [CW-1:0] count_in;
   logic          covers;

   // Candidate covers the reference start when start <= ref < end.
   assign covers = (cand_start <= ref_start) && (ref_start < cand_end);

   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.enable && covers) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end
endmodule

// ===== rtl/max_interval_overlap_core.sv =====
// Top level: interval store, sweep sequencer and result register.
`timescale 1ns / 1ps
// Collects intervals [start, end) one per request, one request a cycle while
// idle with no result pending, into a RAM of MAX_INTERVALS entries; requests
// beyond that are dropped and flagged. A request marked last starts the
// sweep: for every non-empty stored interval the sequencer reads the whole
// store once through the single RAM read port and the shared compare unit
// counts the intervals covering that interval's start; the largest count is
// the result. The sweep is bound by the read port; the result then moves into
// the output register once it is free, and no request is taken meanwhile.
// The result waits in the output register; the next set can load while it
// waits. Intervals ending exactly where another starts do not overlap.
module max_interval_overlap_core #(
   parameter int MAX_INTERVALS = mio_pkg::MAX_INTERVALS_DEF,
   parameter int TIME_BITS     = mio_pkg::TIME_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [mio_pkg::FIELD_W-1:0] req_interval_start,
   input  logic [mio_pkg::FIELD_W-1:0] req_interval_end,
   input  logic                        req_last_interval,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [mio_pkg::ROOMS_W-1:0] rsp_rooms_needed,
   output logic                        rsp_overflow
);
   localparam int AW = $clog2(MAX_INTERVALS);
   localparam int CW = $clog2(MAX_INTERVALS + 1);
   localparam int TW = TIME_BITS;
   localparam int FW = mio_pkg::FIELD_W;
   localparam int RW = mio_pkg::ROOMS_W;

   mio_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          drop_ff, drop_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] peak_ff, peak_in;
   logic          scan_vld_ff, scan_vld_in;
   logic [TW-1:0] ref_start_ff, ref_start_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0] rooms_ff, rooms_in;
   logic          ovf_ff, ovf_in;
   logic          pending_ff, pending_in;

   logic                accept, wr_en;
   logic [FW+TW-1:0]    start_ext, end_ext;
   logic [2*TW-1:0]     wr_data, rd_data;
   logic [AW-1:0]       rd_addr;
   logic [CW-1:0]       cover_count;
   logic [CW+RW-1:0]    peak_ext;
   logic [TW-1:0]       rd_start, rd_end;
   mio_pkg::cover_ctl_type cover_ctl;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == mio_pkg::ST_IDLE) && !pending_ff;
   assign wr_en     = accept && (count_ff < CW'(MAX_INTERVALS));

   // Mask times to TIME_BITS (zero-extend when wider than the port).
   assign start_ext = {{TW{1'b0}}, req_interval_start};
   assign end_ext   = {{TW{1'b0}}, req_interval_end};
   assign wr_data   = {start_ext[TW-1:0], end_ext[TW-1:0]};
   assign rd_start  = rd_data[2*TW-1:TW];
   assign rd_end    = rd_data[TW-1:0];

   assign rd_addr = (state_ff == mio_pkg::ST_SCAN) ? j_ff[AW-1:0] : i_ff[AW-1:0];

   mio_ram #(.WIDTH(2 * TW), .DEPTH(MAX_INTERVALS)) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (count_ff[AW-1:0]),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   assign cover_ctl.clear  = (state_ff == mio_pkg::ST_LATCH);
   assign cover_ctl.enable = scan_vld_ff;

   mio_cover_unit #(.TW(TW), .CW(CW)) u_cover (
      .clock      (clock),
      .ctl        (cover_ctl),
      .ref_start  (ref_start_ff),
      .cand_start (rd_start),
      .cand_end   (rd_end),
      .count_ff   (cover_count)
   );

   assign peak_ext = {{RW{1'b0}}, peak_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      peak_in      = peak_ff;
      ref_start_in = ref_start_ff;
      scan_vld_in  = (state_ff == mio_pkg::ST_SCAN);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rooms_in     = rooms_ff;
      ovf_in       = ovf_ff;
      pending_in   = pending_ff;

      // Publish a finished result once the output register is free.
      if (pending_ff && !rsp_valid_in) begin
         rsp_valid_in = 1'b1;
         rooms_in     = peak_ext[RW-1:0];
         ovf_in       = drop_ff;
         pending_in   = 1'b0;
         count_in     = '0;
         drop_in      = 1'b0;
      end

      unique case (state_ff)
         mio_pkg::ST_IDLE: begin
            if (accept) begin
               if (wr_en) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_last_interval) begin
                  i_in     = '0;
                  peak_in  = '0;
                  state_in = mio_pkg::ST_FETCH;
               end
            end
         end
         mio_pkg::ST_FETCH: begin
            state_in = mio_pkg::ST_LATCH;
         end
         mio_pkg::ST_LATCH: begin
            ref_start_in = rd_start;
            j_in         = '0;
            // Skip empty intervals: they cover no instant.
            if (rd_end <= rd_start) begin
               state_in = mio_pkg::ST_UPDATE;
            end else begin
               state_in = mio_pkg::ST_SCAN;
            end
         end
         mio_pkg::ST_SCAN: begin
            j_in = j_ff + CW'(1);
            if (j_ff == count_ff - CW'(1)) begin
               state_in = mio_pkg::ST_DRAIN;
            end
         end
         mio_pkg::ST_DRAIN: begin
            state_in = mio_pkg::ST_UPDATE;
         end
         mio_pkg::ST_UPDATE: begin
            if (j_ff != '0 && cover_count > peak_ff) begin
               peak_in = cover_count;
            end
            i_in = i_ff + CW'(1);
            if (i_ff == count_ff - CW'(1)) begin
               pending_in = 1'b1;
               state_in   = mio_pkg::ST_IDLE;
            end else begin
               state_in = mio_pkg::ST_FETCH;
            end
         end
         default: begin
            state_in = mio_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mio_pkg::ST_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= 1'b0;
         scan_vld_ff  <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         peak_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         pending_ff   <= pending_in;
         scan_vld_ff  <= scan_vld_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         peak_ff      <= peak_in;
      end
      ref_start_ff <= ref_start_in;
      rooms_ff     <= rooms_in;
      ovf_ff       <= ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rooms_needed = rooms_ff;
   assign rsp_overflow     = ovf_ff;
endmodule

// ===== rtl/mio_checker.sv =====
// Port-level checker for the interval overlap core, bound to the top level.
`timescale 1ns / 1ps
`include "max_interval_overlap_core_assert.svh"
module mio_checker #(
   parameter int MAX_INTERVALS = mio_pkg::MAX_INTERVALS_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_last_interval,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [mio_pkg::ROOMS_W-1:0] rsp_rooms_needed
);
   `MIO_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `MIO_ASSERT_NXT(a_busy_after_last, clock, reset, req_valid && req_ready && req_last_interval, !req_ready)
   `MIO_ASSERT_IMP(a_rooms_bound, clock, reset, rsp_valid, 32'(rsp_rooms_needed) <= 32'(MAX_INTERVALS))
   `MIO_ASSERT_RST(a_reset_quiet, clock, reset, !rsp_valid)
endmodule

bind max_interval_overlap_core mio_checker #(.MAX_INTERVALS(MAX_INTERVALS)) u_mio_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_last_interval (req_last_interval),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_rooms_needed  (rsp_rooms_needed)
);

// ===== tb/tb_top.sv =====
// Testbench for the interval overlap core: directed table, overflow set, random sets.
`timescale 1ns / 1ps
module tb_top;
   localparam int CAP = mio_pkg::MAX_INTERVALS_DEF;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [mio_pkg::FIELD_W-1:0]  req_interval_start = '0;
   logic [mio_pkg::FIELD_W-1:0]  req_interval_end = '0;
   logic                         req_last_interval = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [mio_pkg::ROOMS_W-1:0]  rsp_rooms_needed;
   logic                         rsp_overflow;

   typedef struct {
      logic [mio_pkg::ROOMS_W-1:0] rooms;
      logic                        ovf;
   } overlap_rsp_type;

   // One row of the directed table; typed=1 means the expected count is given here.
   typedef struct {
      logic [31:0]                 s;
      logic [31:0]                 e;
      logic                        last;
      logic                        typed;
      logic [mio_pkg::ROOMS_W-1:0] rooms;
      logic                        ovf;
   } overlap_row_type;

   overlap_rsp_type pending_rsp[$];
   logic [31:0]     set_start[$];
   logic [31:0]     set_end[$];
   logic            set_dropped = 1'b0;
   int              fail_count = 0;
   int              req_count = 0;
   int              rsp_count = 0;
   int              set_count = 0;
   bit              no_idle = 1'b0;
   overlap_row_type dir_rows[12];

   max_interval_overlap_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_interval_start(req_interval_start), .req_interval_end(req_interval_end),
      .req_last_interval(req_last_interval),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_rooms_needed(rsp_rooms_needed), .rsp_overflow(rsp_overflow)
   );

   always #5 clock = ~clock;

   // Peak overlap: for every non-empty interval, count the non-empty intervals
   // that cover its start; half-open, so touching ends do not count.
   function automatic logic [mio_pkg::ROOMS_W-1:0] peak_overlap();
      int best;
      int cnt;
      best = 0;
      for (int i = 0; i < set_start.size(); i++) begin
         if (set_end[i] > set_start[i]) begin
            cnt = 0;
            for (int j = 0; j < set_start.size(); j++)
               if (set_end[j] > set_start[j] && set_start[j] <= set_start[i]
                   && set_start[i] < set_end[j])
                  cnt++;
            if (cnt > best) best = cnt;
         end
      end
      return best[mio_pkg::ROOMS_W-1:0];
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Drive one request and hold it until taken; update the predicted set on acceptance.
   // use_pred=0 on a last request means the caller already queued the typed result.
   task automatic send_interval(input logic [31:0] s, input logic [31:0] e,
                                input logic last, input bit use_pred);
      int gap;
      overlap_rsp_type exp_rsp;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_interval_start <= s;
      req_interval_end   <= e;
      req_last_interval  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      req_count++;
      if (set_start.size() < CAP) begin
         set_start.push_back(s);
         set_end.push_back(e);
      end else begin
         set_dropped = 1'b1;
      end
      if (last) begin
         if (use_pred) begin
            exp_rsp.rooms = peak_overlap();
            exp_rsp.ovf   = set_dropped;
            pending_rsp.push_back(exp_rsp);
         end
         set_start.delete();
         set_end.delete();
         set_dropped = 1'b0;
         set_count++;
      end
   endtask

   task automatic release_req();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly narrow times so intervals collide; sometimes full 32-bit values.
   function automatic logic [31:0] rand_time(input logic [31:0] base, input int mode);
      if (mode == 0) return $urandom();
      return base + $urandom_range(0, 63);
   endfunction

   // Result side: take each result against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result rooms=%0d overflow=%0d", $time,
                     rsp_rooms_needed, rsp_overflow);
            fail_count++;
         end else begin
            if (rsp_rooms_needed !== pending_rsp[0].rooms) begin
               $display("%0t: rooms_needed expected %0d actual %0d", $time,
                        pending_rsp[0].rooms, rsp_rooms_needed);
               fail_count++;
            end
            if (rsp_overflow !== pending_rsp[0].ovf) begin
               $display("%0t: overflow expected %0d actual %0d", $time,
                        pending_rsp[0].ovf, rsp_overflow);
               fail_count++;
            end
            void'(pending_rsp.pop_front());
         end
      end
   end

   // Receiver stalls: mostly ready, short drops, a rare long hold-off.
   initial begin
      int r;
      int hold;
      @(negedge reset);
      forever begin
         r = $urandom_range(0, 99);
         if (no_idle || r < 70) hold = 0;
         else if (r < 97) hold = $urandom_range(1, 4);
         else hold = $urandom_range(20, 80);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Watchdog: the overflow set dominates the runtime; allow plenty beyond it.
   initial begin
      #50_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      overlap_rsp_type typed_rsp;
      int              n;
      int              mode;
      logic [31:0]     base;
      logic [31:0]     s;
      logic [31:0]     e;

      dir_rows = '{
         '{32'h0, 32'hFFFFFFFF, 1'b1, 1'b1, 11'd1, 1'b0},         // widest single
         '{32'd5, 32'd5, 1'b1, 1'b1, 11'd0, 1'b0},                // empty interval
         '{32'hFFFFFFFF, 32'h0, 1'b1, 1'b1, 11'd0, 1'b0},         // reversed, empty
         '{32'd10, 32'd20, 1'b0, 1'b0, 11'd0, 1'b0},
         '{32'd20, 32'd30, 1'b1, 1'b1, 11'd1, 1'b0},              // touching ends
         '{32'h0, 32'hFFFFFFFF, 1'b0, 1'b0, 11'd0, 1'b0},
         '{32'hFFFFFFFE, 32'hFFFFFFFF, 1'b1, 1'b1, 11'd2, 1'b0},  // nested at the top
         '{32'd100, 32'd200, 1'b0, 1'b0, 11'd0, 1'b0},
         '{32'd150, 32'd250, 1'b0, 1'b0, 11'd0, 1'b0},
         '{32'd120, 32'd130, 1'b0, 1'b0, 11'd0, 1'b0},
         '{32'd50, 32'd90, 1'b1, 1'b0, 11'd0, 1'b0},
         '{32'h5555AAAA, 32'hAAAA5555, 1'b1, 1'b0, 11'd0, 1'b0}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table.
      foreach (dir_rows[i]) begin
         if (dir_rows[i].last && dir_rows[i].typed) begin
            typed_rsp.rooms = dir_rows[i].rooms;
            typed_rsp.ovf   = dir_rows[i].ovf;
            pending_rsp.push_back(typed_rsp);
         end
         send_interval(dir_rows[i].s, dir_rows[i].e, dir_rows[i].last, !dir_rows[i].typed);
      end

      // Fill the store: three real intervals, the rest empty so the sweep stays short.
      // Then a dropped non-final request and a dropped final one that still closes the set.
      no_idle = 1'b1;
      for (int i = 0; i < CAP; i++) begin
         if (i < 3) send_interval(32'd0, 32'd100, 1'b0, 1'b1);
         else send_interval(32'd7, 32'd3, 1'b0, 1'b1);
      end
      send_interval(32'd0, 32'd100, 1'b0, 1'b1);
      typed_rsp.rooms = 11'd3;
      typed_rsp.ovf   = 1'b1;
      pending_rsp.push_back(typed_rsp);
      send_interval(32'd0, 32'd50, 1'b1, 1'b0);
      no_idle = 1'b0;

      // Hold the sender until every result so far is back.
      release_req();
      while (pending_rsp.size() != 0) @(posedge clock);

      // Random sets: mostly small and well collided, a few larger or wide-valued.
      while (req_count < 2000) begin
         no_idle = ($urandom_range(0, 9) == 0);
         n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         mode = $urandom_range(0, 4);
         base = ($urandom_range(0, 3) == 0) ? 32'hFFFFFF00 : $urandom_range(0, 1000);
         for (int k = 0; k < n; k++) begin
            s = rand_time(base, mode);
            e = ($urandom_range(0, 9) == 0) ? s : s + rand_time(32'd1, mode);
            if (mode != 0 && $urandom_range(0, 9) == 0) e = s - 1;
            send_interval(s, e, k == n - 1, 1'b1);
         end
      end
      release_req();

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Covered %0d requests in %0d sets, %0d results checked,", req_count,
               set_count, rsp_count);
      $display("including a full store with dropped requests and random stalls.");
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
